// ----- design/sic_pkg.sv -----
// Shared types and constants for the stereo input conditioner.
package sic_pkg;

  localparam int SAMPLE_BITS = 24;

  // Internal word widths, all derived from the sample width
  localparam int SW  = SAMPLE_BITS + 1;   // sample after optional negation
  localparam int GPW = SW + 17;           // sample times gain
  localparam int GW  = SAMPLE_BITS + 5;   // gained sample
  localparam int PPW = GW + 17;           // gained sample times pan factor
  localparam int PW  = SAMPLE_BITS + 6;   // panned sample
  localparam int MW  = PW + 17;           // width-mix products
  localparam int DW  = MW + 1;            // width-mix difference

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT_LEFT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT_RIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINEAR_GAIN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAN_POSITION = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEREO_WIDTH = 3'd4;

  localparam logic [15:0] GAIN_MIN   = 16'd258;
  localparam logic [15:0] GAIN_MAX   = 16'd64918;
  localparam logic [15:0] GAIN_UNITY = 16'd4096;
  localparam logic signed [16:0] Q14_ONE = 17'sd16384;
  localparam logic [15:0] Q14_ONE_U  = 16'd16384;
  localparam logic [15:0] Q15_ONE_U  = 16'd32768;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } sic_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } sic_out_t;

endpackage

// ----- design/stereo_input_conditioner_core.sv -----
// Stereo input conditioner: phase invert, gain, pan and width mix in a five-stage pipeline.
//
// Use of the block:
//   Input channel  : in_valid / in_stall / in_data (left_in, right_in). An item is taken
//                    at a rising edge with in_valid high and in_stall low.
//   Output channel : out_valid / out_stall / out_data (left_out, right_out), same rule.
//   Config channel : cfg_valid / cfg_ready / cfg_index / cfg_data. cfg_ready is always
//                    high; write only while no item is in flight. Indexes: 0 invert left,
//                    1 invert right, 2 linear gain (Q4.12), 3 pan (Q1.14), 4 width (Q1.14).
//                    Unknown indexes are dropped. Gain, pan and width are clamped on write.
//   Stages         : an accepted item passes five register stages (invert, gain, pan,
//                    width products, mix/round/saturate) before out_valid rises for it.
//   Throughput     : one stereo item per cycle unless out_stall holds the pipeline; each
//                    stage holds one item; the multiplying stages work on different items.
//   Reset (rst, synchronous, active high): pipeline empties, registers return to unity
//                    gain, centre pan, normal width and no inversion.
//   Receiver stall : the last stage holds its item; a stage only stalls when it and
//                    every stage after it are full, so bubbles are squeezed out and
//                    in_stall rises only once the whole pipeline is full.
module stereo_input_conditioner_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sic_pkg::sic_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sic_pkg::sic_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sic_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [sic_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import sic_pkg::*;

  localparam int S = SAMPLE_BITS;
  localparam logic signed [GPW-1:0] RND12 = GPW'(2048);
  localparam logic signed [PPW-1:0] RND14 = PPW'(8192);
  localparam logic signed [DW-1:0]  RND15 = DW'(16384);
  localparam int OW = DW - 15;
  localparam logic signed [OW-1:0] SAT_HI = {{(OW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [OW-1:0] SAT_LO = {{(OW-S+1){1'b1}}, {(S-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers, held in the form the datapath wants
  // ---------------------------------------------------------------------------
  logic               inv_l, inv_r;
  logic [15:0]        gain;       // clamped Q4.12
  logic [15:0]        pan_fl;     // 1 - pan, Q1.14, 0..32768
  logic [15:0]        pan_fr;     // 1 + pan
  logic [15:0]        wid_f;      // 2 - |w|, Q1.14, 16384..32768
  logic signed [15:0] wid;        // clamped w

  logic signed [16:0] cfg_s;
  logic signed [16:0] cfg_clamp;
  logic signed [16:0] cfg_abs;
  logic [15:0]        gain_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_s = $signed({cfg_data[15], cfg_data});
    if (cfg_s > Q14_ONE) begin
      cfg_clamp = Q14_ONE;
    end else if (cfg_s < -Q14_ONE) begin
      cfg_clamp = -Q14_ONE;
    end else begin
      cfg_clamp = cfg_s;
    end
    cfg_abs = (cfg_clamp < 0) ? -cfg_clamp : cfg_clamp;
    if (cfg_data < GAIN_MIN) begin
      gain_next = GAIN_MIN;
    end else if (cfg_data > GAIN_MAX) begin
      gain_next = GAIN_MAX;
    end else begin
      gain_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_l  <= 1'b0;
      inv_r  <= 1'b0;
      gain   <= GAIN_UNITY;
      pan_fl <= Q14_ONE_U;
      pan_fr <= Q14_ONE_U;
      wid_f  <= Q15_ONE_U;
      wid    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INVERT_LEFT:  inv_l <= cfg_data[0];
        CFG_INVERT_RIGHT: inv_r <= cfg_data[0];
        CFG_LINEAR_GAIN:  gain  <= gain_next;
        CFG_PAN_POSITION: begin
          pan_fl <= 16'(Q14_ONE - cfg_clamp);
          pan_fr <= 16'(Q14_ONE + cfg_clamp);
        end
        CFG_STEREO_WIDTH: begin
          wid_f <= 16'((Q14_ONE <<< 1) - cfg_abs);
          wid   <= 16'(cfg_clamp);
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage moves when it is empty or the next one moves
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5      = !v5 || !out_stall;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: phase inversion (one extra bit so the most negative sample flips cleanly)
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s_l, s_r;
  logic signed [SW-1:0] s_l_next, s_r_next;

  always_comb begin
    s_l_next = SW'(in_data.left_in);
    s_r_next = SW'(in_data.right_in);
    if (inv_l) s_l_next = -s_l_next;
    if (inv_r) s_r_next = -s_r_next;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s_l <= s_l_next;
      s_r <= s_r_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gain, round half up at 2^12
  // ---------------------------------------------------------------------------
  logic signed [GPW-1:0] gp_l, gp_r;
  logic signed [GW-1:0]  g_l, g_r;

  assign gp_l = s_l * $signed({1'b0, gain}) + RND12;
  assign gp_r = s_r * $signed({1'b0, gain}) + RND12;

  always_ff @(posedge clk) begin
    if (en2) begin
      g_l <= gp_l[GW+11:12];
      g_r <= gp_r[GW+11:12];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pan, round half up at 2^14
  // ---------------------------------------------------------------------------
  logic signed [PPW-1:0] pp_l, pp_r;
  logic signed [PW-1:0]  p_l, p_r;

  assign pp_l = g_l * $signed({1'b0, pan_fl}) + RND14;
  assign pp_r = g_r * $signed({1'b0, pan_fr}) + RND14;

  always_ff @(posedge clk) begin
    if (en3) begin
      p_l <= pp_l[PW+13:14];
      p_r <= pp_r[PW+13:14];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: width-mix products, direct and cross terms
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] m_ll, m_rr, m_lx, m_rx;

  always_ff @(posedge clk) begin
    if (en4) begin
      m_ll <= p_l * $signed({1'b0, wid_f});
      m_rr <= p_r * $signed({1'b0, wid_f});
      m_lx <= p_r * wid;   // cross term into the left output
      m_rx <= p_l * wid;   // cross term into the right output
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: mix, round half up at 2^15, saturate
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] d_l, d_r;
  logic signed [OW-1:0] r_l, r_r;
  logic signed [S-1:0]  o_l_next, o_r_next;
  sic_out_t             o_reg;

  assign d_l = DW'(m_ll) - DW'(m_lx) + RND15;
  assign d_r = DW'(m_rr) - DW'(m_rx) + RND15;
  assign r_l = d_l[DW-1:15];
  assign r_r = d_r[DW-1:15];

  always_comb begin
    if (r_l > SAT_HI) begin
      o_l_next = SAT_HI[S-1:0];
    end else if (r_l < SAT_LO) begin
      o_l_next = SAT_LO[S-1:0];
    end else begin
      o_l_next = r_l[S-1:0];
    end
    if (r_r > SAT_HI) begin
      o_r_next = SAT_HI[S-1:0];
    end else if (r_r < SAT_LO) begin
      o_r_next = SAT_LO[S-1:0];
    end else begin
      o_r_next = r_r[S-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      o_reg.left_out  <= o_l_next;
      o_reg.right_out <= o_r_next;
    end
  end

  assign out_valid = v5;
  assign out_data  = o_reg;

endmodule
